// File: src/sfa_pkg.sv
package sfa_pkg;

  // Fixed granule size: every header sits on an 8-byte boundary
  localparam int GRANULE_BYTES = 8;
  // Rounded request size needs one bit more than the request field
  localparam int SIZE_W = 18;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  // One input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [16:0] request_size;
    logic [15:0] block_address;
  } sfa_req_t;

  // One result item
  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } sfa_rsp_t;

endpackage

// File: src/segregated_free_list_allocator.sv
// One item in flight; a result register lets the next item start while
// the previous result waits. Allocate and free last longer the more header
// memory read-modify-write steps they need; rejected items finish soonest.
// Initialise sweeps the used bit of every header to zero.
// Synchronous active-low reset: free lists empty, heap_bytes = 65536,
// no result pending; header memory contents are undefined until initialise.
module segregated_free_list_allocator #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 64,
  parameter int NUM_CLASSES  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_payload_address,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_heap_bytes
);
  import sfa_pkg::*;

  logic        ctrl_idle, ctrl_done, out_free, in_acc;
  sfa_req_t    req;
  sfa_rsp_t    rsp;
  logic [16:0] heap_r;
  logic        out_valid_r;
  sfa_rsp_t    out_r;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= 17'h10000;
    end else if (cfg_valid && cfg_ready) begin
      heap_r <= cfg_heap_bytes;
    end
  end

  assign in_stall = !ctrl_idle;
  assign in_acc   = in_valid && !in_stall;
  assign req      = '{operation: in_operation, request_size: in_request_size,
                      block_address: in_block_address};
  assign out_free = !out_valid_r || !out_stall;

  sfa_ctrl #(
    .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .req(req),
    .heap_bytes(heap_r), .out_free(out_free), .idle(ctrl_idle),
    .done(ctrl_done), .rsp(rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl_done) begin
      out_r <= rsp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_address = out_r.payload_address;
  assign out_status          = out_r.status;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after an item was accepted");

  a_done_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_done |=> out_valid_r)
    else $error("finished item did not reach the result register");

  a_fail_has_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_payload_address == 16'd0))
    else $error("failed item carries a nonzero address");

endmodule

// File: src/sfa_ram.sv
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: src/sfa_ctrl.sv
module sfa_ctrl #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 64,
  parameter int NUM_CLASSES  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sfa_pkg::sfa_req_t req,
  input  logic [16:0]      heap_bytes,
  input  logic             out_free,
  output logic             idle,
  output logic             done,
  output sfa_pkg::sfa_rsp_t rsp
);
  import sfa_pkg::*;

  localparam int GRAN  = HEAP_BYTES / GRANULE_BYTES;
  localparam int GW    = $clog2(GRAN);
  localparam int LW    = GW + 1;
  localparam int LENW  = $clog2(HEAP_BYTES);
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int WA    = (LENW > SIZE_W) ? LENW : SIZE_W;
  localparam int WW    = ((WA > LW) ? WA : LW) + 2;
  localparam int MW    = LENW + 4 * LW;

  localparam logic [LW-1:0] NIL    = {LW{1'b1}};
  localparam logic [LW-1:0] GRAN_L = LW'(GRAN);
  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] GRAN_W = WW'(GRAN);
  localparam logic [WW-1:0] HEAP_W = WW'(HEAP_BYTES);

  // Header entry; used is the MSB and lives in its own RAM
  typedef struct packed {
    logic            used;
    logic [LENW-1:0] len;
    logic [LW-1:0]   lnk_next;
    logic [LW-1:0]   lnk_prev;
    logic [LW-1:0]   free_next;
    logic [LW-1:0]   free_prev;
  } ent_t;

  typedef enum logic [1:0] {F_NEXT, F_PREV, F_FNEXT, F_FPREV} fld_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_INIT_E,
    S_A_LD, S_A_SPL, S_A_LNK, S_A_WB2, S_A_WB,
    S_F_G, S_F_P, S_F_PJ, S_F_N0, S_F_N, S_F_NJ, S_F_FILE, S_F_WB,
    S_UL0, S_UL1, S_PT_RD, S_PT_WR, S_DONE
  } state_t;

  function automatic logic lv(input logic [LW-1:0] l);
    return l < GRAN_L;
  endfunction

  // Free-list class of a block length: first c with len <= 2^(c+1)
  function automatic logic [CW-1:0] cls_of_len(input logic [LENW-1:0] len);
    logic [CW-1:0] c;
    c = CW'(NUM_CLASSES - 1);
    for (int x = NUM_CLASSES - 1; x >= 0; x--) begin
      if (64'(len) <= (64'd1 << (x + 1))) begin
        c = CW'(x);
      end
    end
    return c;
  endfunction

  function automatic ent_t set_fld(input ent_t e, input fld_t f,
                                   input logic [LW-1:0] v);
    ent_t r;
    r = e;
    case (f)
      F_NEXT:  r.lnk_next  = v;
      F_PREV:  r.lnk_prev  = v;
      F_FNEXT: r.free_next = v;
      F_FPREV: r.free_prev = v;
    endcase
    return r;
  endfunction

  state_t          state_r, state_nxt, ret_r, ret_nxt, ul_ret_r, ul_ret_nxt;
  logic [LW-1:0]   heads_r [NUM_CLASSES];
  logic [LW-1:0]   heads_nxt [NUM_CLASSES];
  logic [CW-1:0]   cls_r, cls_nxt;
  logic [WW-1:0]   size_r, size_nxt;
  logic [GW-1:0]   idx_a_r, idx_a_nxt, idx_b_r, idx_b_nxt;
  ent_t            ent_a_r, ent_a_nxt, ent_b_r, ent_b_nxt;
  logic            a_v_r, a_v_nxt, b_v_r, b_v_nxt;
  logic            err_r, err_nxt;
  logic [GW-1:0]   sweep_r, sweep_nxt;
  logic [GW-1:0]   pt_addr_r, pt_addr_nxt;
  fld_t            pt_fld_r, pt_fld_nxt;
  logic [LW-1:0]   pt_val_r, pt_val_nxt;
  sfa_rsp_t        rsp_r, rsp_nxt;

  // Header memories
  logic            m_we, u_we;
  logic [GW-1:0]   w_addr, r_addr;
  ent_t            wr_ent, rd_ent;
  logic [MW-1:0]   m_rd;
  logic            u_rd;

  sfa_ram #(.WIDTH(MW), .DEPTH(GRAN)) u_link_ram (
    .clk(clk), .we(m_we), .wr_addr(w_addr), .wr_data(wr_ent[MW-1:0]),
    .rd_addr(r_addr), .rd_data(m_rd)
  );

  sfa_ram #(.WIDTH(1), .DEPTH(GRAN)) u_used_ram (
    .clk(clk), .we(u_we), .wr_addr(w_addr), .wr_data(wr_ent.used),
    .rd_addr(r_addr), .rd_data(u_rd)
  );

  assign rd_ent = {u_rd, m_rd};

  // Request decode
  logic [WW-1:0] size_in, fa, off;
  logic          free_ok;
  logic [GW-1:0] free_g;
  assign size_in = (WW'(req.request_size) + WW'(7)) & ~WW'(7);
  assign fa      = WW'(req.block_address);
  assign off     = fa - HDR_W;
  assign free_ok = (fa != '0) && (fa >= HDR_W) && (off[2:0] == 3'd0) &&
                   ((off >> 3) < GRAN_W);
  assign free_g  = GW'(off >> 3);

  // Allocation class: first non-empty class with size <= 2^c
  logic          alloc_hit;
  logic [CW-1:0] alloc_cls;
  always_comb begin
    alloc_hit = 1'b0;
    alloc_cls = '0;
    for (int x = NUM_CLASSES - 1; x >= 0; x--) begin
      if (64'(size_in) <= (64'd1 << x) && lv(heads_r[x])) begin
        alloc_hit = 1'b1;
        alloc_cls = CW'(x);
      end
    end
  end

  // Split of the popped block
  logic [WW-1:0]   len_a_w, nb_w;
  logic            split_ok;
  logic [LENW-1:0] split_len;
  assign len_a_w   = WW'(ent_a_r.len);
  assign nb_w      = WW'(idx_a_r) + ((HDR_W + size_r) >> 3);
  assign split_ok  = (len_a_w >= size_r + WW'(8) + HDR_W) && (nb_w < GRAN_W);
  assign split_len = LENW'(len_a_w - size_r - HDR_W);

  // Region size for initialise
  logic [WW-1:0]   hb, h;
  logic            init_ok;
  logic [LENW-1:0] init_len;
  assign hb       = WW'({heap_bytes[16:3], 3'b000});
  assign h        = (hb > HEAP_W) ? HEAP_W : hb;
  assign init_ok  = h > HDR_W;
  assign init_len = LENW'(h - HDR_W);

  // List head holding the block being unlinked
  logic          hs_hit;
  logic [CW-1:0] hs_idx;
  always_comb begin
    hs_hit = 1'b0;
    hs_idx = '0;
    for (int x = NUM_CLASSES - 1; x >= 0; x--) begin
      if (heads_r[x] == LW'(idx_b_r)) begin
        hs_hit = 1'b1;
        hs_idx = CW'(x);
      end
    end
  end

  // Forwarding from held entries over the memory copy
  logic pt_a_hit, pt_b_hit;
  ent_t pt_src, pt_new, cap_b;
  assign pt_a_hit = a_v_r && (pt_addr_r == idx_a_r);
  assign pt_b_hit = b_v_r && (pt_addr_r == idx_b_r);
  assign pt_src   = pt_a_hit ? ent_a_r : (pt_b_hit ? ent_b_r : rd_ent);
  assign pt_new   = set_fld(pt_src, pt_fld_r, pt_val_r);
  assign cap_b    = (a_v_r && (idx_b_r == idx_a_r)) ? ent_a_r : rd_ent;

  logic [LENW-1:0] len_j;
  logic [CW-1:0]   fc_b, fc_a, fc_i;
  assign fc_b = cls_of_len(ent_b_r.len);
  assign fc_a = cls_of_len(ent_a_r.len);
  assign fc_i = cls_of_len(init_len);
  assign len_j = LENW'(WW'(ent_a_r.len) + WW'(ent_b_r.len) + HDR_W);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    ul_ret_nxt = ul_ret_r;
    heads_nxt  = heads_r;
    cls_nxt    = cls_r;
    size_nxt   = size_r;
    idx_a_nxt  = idx_a_r;
    idx_b_nxt  = idx_b_r;
    ent_a_nxt  = ent_a_r;
    ent_b_nxt  = ent_b_r;
    a_v_nxt    = a_v_r;
    b_v_nxt    = b_v_r;
    err_nxt    = err_r;
    sweep_nxt  = sweep_r;
    pt_addr_nxt = pt_addr_r;
    pt_fld_nxt = pt_fld_r;
    pt_val_nxt = pt_val_r;
    rsp_nxt    = rsp_r;
    m_we       = 1'b0;
    u_we       = 1'b0;
    w_addr     = idx_a_r;
    wr_ent     = ent_a_r;
    r_addr     = pt_addr_r;
    done       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          a_v_nxt = 1'b0;
          b_v_nxt = 1'b0;
          err_nxt = 1'b0;
          rsp_nxt = '{payload_address: 16'd0, status: ST_NONE};
          state_nxt = S_DONE;
          unique case (req.operation)
            OP_ALLOC: begin
              if (req.request_size != '0 && alloc_hit) begin
                cls_nxt   = alloc_cls;
                size_nxt  = size_in;
                idx_a_nxt = heads_r[alloc_cls][GW-1:0];
                r_addr    = heads_r[alloc_cls][GW-1:0];
                state_nxt = S_A_LD;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                idx_a_nxt = free_g;
                r_addr    = free_g;
                state_nxt = S_F_G;
              end
            end
            OP_INIT: begin
              for (int x = 0; x < NUM_CLASSES; x++) begin
                heads_nxt[x] = NIL;
              end
              sweep_nxt = '0;
              state_nxt = S_INIT;
            end
            default: ;
          endcase
        end
      end

      // Clear every used bit, one header per cycle
      S_INIT: begin
        u_we      = 1'b1;
        w_addr    = sweep_r;
        wr_ent.used = 1'b0;
        sweep_nxt = sweep_r + GW'(1);
        if (sweep_r == GW'(GRAN - 1)) begin
          state_nxt = S_INIT_E;
        end
      end

      S_INIT_E: begin
        if (init_ok) begin
          m_we   = 1'b1;
          u_we   = 1'b1;
          w_addr = '0;
          wr_ent = '{used: 1'b0, len: init_len, lnk_next: NIL, lnk_prev: NIL,
                     free_next: NIL, free_prev: NIL};
          heads_nxt[fc_i] = '0;
        end
        rsp_nxt   = '{payload_address: 16'd0, status: ST_OK};
        state_nxt = S_DONE;
      end

      // Allocate: pop the list head
      S_A_LD: begin
        ent_a_nxt      = rd_ent;
        ent_a_nxt.used = 1'b1;
        a_v_nxt        = 1'b1;
        heads_nxt[cls_r] = rd_ent.free_next;
        if (lv(rd_ent.free_next)) begin
          pt_addr_nxt = rd_ent.free_next[GW-1:0];
          pt_fld_nxt  = F_FPREV;
          pt_val_nxt  = NIL;
          ret_nxt     = S_A_SPL;
          state_nxt   = S_PT_RD;
        end else begin
          state_nxt = S_A_SPL;
        end
      end

      S_A_SPL: begin
        if (split_ok) begin
          idx_b_nxt = nb_w[GW-1:0];
          b_v_nxt   = 1'b1;
          ent_b_nxt = '{used: 1'b0, len: split_len, lnk_next: ent_a_r.lnk_next,
                        lnk_prev: LW'(idx_a_r), free_next: NIL, free_prev: NIL};
          ent_a_nxt.len = LENW'(size_r);
          if (lv(ent_a_r.lnk_next)) begin
            pt_addr_nxt = ent_a_r.lnk_next[GW-1:0];
            pt_fld_nxt  = F_PREV;
            pt_val_nxt  = LW'(nb_w);
            ret_nxt     = S_A_LNK;
            state_nxt   = S_PT_RD;
          end else begin
            state_nxt = S_A_LNK;
          end
        end else begin
          state_nxt = S_A_WB;
        end
      end

      // File the split-off tail
      S_A_LNK: begin
        ent_a_nxt.lnk_next  = LW'(idx_b_r);
        ent_b_nxt.used      = 1'b0;
        ent_b_nxt.free_prev = NIL;
        ent_b_nxt.free_next = heads_r[fc_b];
        heads_nxt[fc_b]     = LW'(idx_b_r);
        if (lv(heads_r[fc_b])) begin
          pt_addr_nxt = heads_r[fc_b][GW-1:0];
          pt_fld_nxt  = F_FPREV;
          pt_val_nxt  = LW'(idx_b_r);
          ret_nxt     = S_A_WB2;
          state_nxt   = S_PT_RD;
        end else begin
          state_nxt = S_A_WB2;
        end
      end

      S_A_WB2: begin
        m_we      = 1'b1;
        u_we      = 1'b1;
        w_addr    = idx_b_r;
        wr_ent    = ent_b_r;
        b_v_nxt   = 1'b0;
        state_nxt = S_A_WB;
      end

      S_A_WB: begin
        m_we    = 1'b1;
        u_we    = 1'b1;
        rsp_nxt = '{payload_address: 16'((WW'(idx_a_r) << 3) + HDR_W),
                    status: ST_OK};
        state_nxt = S_DONE;
      end

      // Free: check the header, then look at the physical predecessor
      S_F_G: begin
        if (!rd_ent.used) begin
          rsp_nxt   = '{payload_address: 16'd0, status: ST_NONE};
          state_nxt = S_DONE;
        end else begin
          ent_a_nxt      = rd_ent;
          ent_a_nxt.used = 1'b0;
          a_v_nxt        = 1'b1;
          if (lv(rd_ent.lnk_prev)) begin
            idx_b_nxt = rd_ent.lnk_prev[GW-1:0];
            r_addr    = rd_ent.lnk_prev[GW-1:0];
            state_nxt = S_F_P;
          end else begin
            state_nxt = S_F_N0;
          end
        end
      end

      S_F_P: begin
        if (cap_b.used) begin
          state_nxt = S_F_N0;
        end else begin
          ent_b_nxt  = cap_b;
          b_v_nxt    = 1'b1;
          ul_ret_nxt = S_F_PJ;
          state_nxt  = S_UL0;
        end
      end

      // Unlink the held neighbor from its free list
      S_UL0: begin
        if (lv(ent_b_r.free_next)) begin
          pt_addr_nxt = ent_b_r.free_next[GW-1:0];
          pt_fld_nxt  = F_FPREV;
          pt_val_nxt  = ent_b_r.free_prev;
          ret_nxt     = S_UL1;
          state_nxt   = S_PT_RD;
        end else begin
          state_nxt = S_UL1;
        end
      end

      S_UL1: begin
        if (lv(ent_b_r.free_prev)) begin
          pt_addr_nxt = ent_b_r.free_prev[GW-1:0];
          pt_fld_nxt  = F_FNEXT;
          pt_val_nxt  = ent_b_r.free_next;
          ret_nxt     = ul_ret_r;
          state_nxt   = S_PT_RD;
        end else begin
          if (hs_hit) begin
            heads_nxt[hs_idx] = ent_b_r.free_next;
          end
          state_nxt = ul_ret_r;
        end
      end

      // Merge predecessor with the freed block; predecessor becomes current
      S_F_PJ: begin
        m_we      = 1'b1;
        u_we      = 1'b1;
        ent_a_nxt = ent_b_r;
        idx_a_nxt = idx_b_r;
        b_v_nxt   = 1'b0;
        state_nxt = S_F_N0;
        if (idx_b_r >= idx_a_r || ent_b_r.used || ent_a_r.used) begin
          err_nxt = 1'b1;
        end else begin
          ent_a_nxt.len      = len_j;
          ent_a_nxt.lnk_next = ent_a_r.lnk_next;
          if (lv(ent_a_r.lnk_next)) begin
            pt_addr_nxt = ent_a_r.lnk_next[GW-1:0];
            pt_fld_nxt  = F_PREV;
            pt_val_nxt  = LW'(idx_b_r);
            ret_nxt     = S_F_N0;
            state_nxt   = S_PT_RD;
          end
        end
      end

      S_F_N0: begin
        if (lv(ent_a_r.lnk_next)) begin
          idx_b_nxt = ent_a_r.lnk_next[GW-1:0];
          r_addr    = ent_a_r.lnk_next[GW-1:0];
          state_nxt = S_F_N;
        end else begin
          state_nxt = S_F_FILE;
        end
      end

      S_F_N: begin
        if (cap_b.used) begin
          state_nxt = S_F_FILE;
        end else begin
          ent_b_nxt  = cap_b;
          b_v_nxt    = 1'b1;
          ul_ret_nxt = S_F_NJ;
          state_nxt  = S_UL0;
        end
      end

      // Merge the successor into the current block
      S_F_NJ: begin
        b_v_nxt   = 1'b0;
        state_nxt = S_F_FILE;
        if (idx_a_r >= idx_b_r || ent_a_r.used || ent_b_r.used) begin
          err_nxt = 1'b1;
        end else begin
          ent_a_nxt.len      = len_j;
          ent_a_nxt.lnk_next = ent_b_r.lnk_next;
          if (lv(ent_b_r.lnk_next)) begin
            pt_addr_nxt = ent_b_r.lnk_next[GW-1:0];
            pt_fld_nxt  = F_PREV;
            pt_val_nxt  = LW'(idx_a_r);
            ret_nxt     = S_F_FILE;
            state_nxt   = S_PT_RD;
          end
        end
      end

      S_F_FILE: begin
        ent_a_nxt.used      = 1'b0;
        ent_a_nxt.free_prev = NIL;
        ent_a_nxt.free_next = heads_r[fc_a];
        heads_nxt[fc_a]     = LW'(idx_a_r);
        if (lv(heads_r[fc_a])) begin
          pt_addr_nxt = heads_r[fc_a][GW-1:0];
          pt_fld_nxt  = F_FPREV;
          pt_val_nxt  = LW'(idx_a_r);
          ret_nxt     = S_F_WB;
          state_nxt   = S_PT_RD;
        end else begin
          state_nxt = S_F_WB;
        end
      end

      S_F_WB: begin
        m_we    = 1'b1;
        u_we    = 1'b1;
        rsp_nxt = '{payload_address: 16'd0, status: err_r ? ST_MERGE : ST_OK};
        state_nxt = S_DONE;
      end

      // Read-modify-write of one link field
      S_PT_RD: begin
        r_addr    = pt_addr_r;
        state_nxt = S_PT_WR;
      end

      S_PT_WR: begin
        m_we   = 1'b1;
        u_we   = 1'b1;
        w_addr = pt_addr_r;
        wr_ent = pt_new;
        if (pt_a_hit) begin
          ent_a_nxt = pt_new;
        end
        if (pt_b_hit) begin
          ent_b_nxt = pt_new;
        end
        state_nxt = ret_r;
      end

      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      err_r   <= 1'b0;
      for (int x = 0; x < NUM_CLASSES; x++) begin
        heads_r[x] <= NIL;
      end
    end else begin
      state_r <= state_nxt;
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      err_r   <= err_nxt;
      heads_r <= heads_nxt;
    end
    ret_r     <= ret_nxt;
    ul_ret_r  <= ul_ret_nxt;
    cls_r     <= cls_nxt;
    size_r    <= size_nxt;
    idx_a_r   <= idx_a_nxt;
    idx_b_r   <= idx_b_nxt;
    ent_a_r   <= ent_a_nxt;
    ent_b_r   <= ent_b_nxt;
    sweep_r   <= sweep_nxt;
    pt_addr_r <= pt_addr_nxt;
    pt_fld_r  <= pt_fld_nxt;
    pt_val_r  <= pt_val_nxt;
    rsp_r     <= rsp_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign rsp  = rsp_r;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfa_pkg::*;

  localparam int HEAP_MAX   = 65536;
  localparam int HDR_BYTES  = 64;
  localparam int N_CLASS    = 16;
  localparam int N_GRAN     = HEAP_MAX / GRANULE_BYTES;
  localparam int unsigned NONE = 32'hFFFF_FFFF;
  // Operation code with no meaning
  localparam logic [1:0] OP_UNDEF = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [16:0] in_request_size;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_payload_address;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_heap_bytes;

  segregated_free_list_allocator i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_address (out_payload_address),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_heap_bytes      (cfg_heap_bytes)
  );

  // Heap mirror
  int unsigned hp_next [N_GRAN];
  int unsigned hp_prev [N_GRAN];
  int unsigned hp_fnext[N_GRAN];
  int unsigned hp_fprev[N_GRAN];
  int unsigned hp_len  [N_GRAN];
  bit          hp_used [N_GRAN];
  int unsigned hp_heads[N_CLASS];
  int unsigned heap_size;

  sfa_rsp_t    expected_rsp[$];
  int unsigned live_blocks[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit is_gran(int unsigned i);
    return i < N_GRAN;
  endfunction

  function automatic void heap_file(int unsigned b);
    int unsigned c;
    c = N_CLASS - 1;
    for (int x = 0; x < N_CLASS; x++) begin
      if (longint'(hp_len[b]) <= (longint'(1) << (x + 1))) begin
        c = x;
        break;
      end
    end
    hp_used[b]  = 1'b0;
    hp_fprev[b] = NONE;
    hp_fnext[b] = hp_heads[c];
    if (is_gran(hp_heads[c])) hp_fprev[hp_heads[c]] = b;
    hp_heads[c] = b;
  endfunction

  function automatic void heap_unlink(int unsigned b);
    if (is_gran(hp_fnext[b])) hp_fprev[hp_fnext[b]] = hp_fprev[b];
    if (is_gran(hp_fprev[b])) begin
      hp_fnext[hp_fprev[b]] = hp_fnext[b];
    end else begin
      for (int x = 0; x < N_CLASS; x++) begin
        if (hp_heads[x] == b) begin
          hp_heads[x] = hp_fnext[b];
          break;
        end
      end
    end
  endfunction

  function automatic int unsigned heap_join(int unsigned a, int unsigned b, ref bit err);
    if (a >= b || hp_used[a] || hp_used[b]) begin
      err = 1'b1;
      return a;
    end
    hp_len[a]  = hp_len[a] + hp_len[b] + HDR_BYTES;
    hp_next[a] = hp_next[b];
    if (is_gran(hp_next[a])) hp_prev[hp_next[a]] = a;
    return a;
  endfunction

  function automatic void heap_init();
    longint h;
    h = longint'(heap_size & ~32'd7);
    if (h > HEAP_MAX) h = HEAP_MAX;
    for (int x = 0; x < N_CLASS; x++) hp_heads[x] = NONE;
    for (int g = 0; g < N_GRAN; g++) hp_used[g] = 1'b0;
    live_blocks.delete();
    if (h > HDR_BYTES) begin
      hp_len[0]  = int'(h - HDR_BYTES);
      hp_next[0] = NONE;
      hp_prev[0] = NONE;
      heap_file(0);
    end
  endfunction

  function automatic sfa_rsp_t heap_alloc(logic [16:0] req);
    sfa_rsp_t    r;
    longint      size;
    int unsigned b, nb;
    r = '{payload_address: '0, status: ST_NONE};
    if (req == 0) return r;
    size = (longint'(req) + 7) & ~longint'(7);
    b = NONE;
    for (int x = 0; x < N_CLASS; x++) begin
      if (size <= (longint'(1) << x) && is_gran(hp_heads[x])) begin
        b = hp_heads[x];
        hp_heads[x] = hp_fnext[b];
        if (is_gran(hp_heads[x])) hp_fprev[hp_heads[x]] = NONE;
        hp_used[b] = 1'b1;
        break;
      end
    end
    if (!is_gran(b)) return r;
    // split off the tail when a usable block remains
    if (longint'(hp_len[b]) >= size + 8 + HDR_BYTES) begin
      nb = b + int'((HDR_BYTES + size) / GRANULE_BYTES);
      if (is_gran(nb)) begin
        hp_len[nb]  = hp_len[b] - int'(size) - HDR_BYTES;
        hp_used[nb] = 1'b0;
        hp_len[b]   = int'(size);
        hp_prev[nb] = b;
        hp_next[nb] = hp_next[b];
        if (is_gran(hp_next[nb])) hp_prev[hp_next[nb]] = nb;
        hp_next[b] = nb;
        heap_file(nb);
      end
    end
    r.status = ST_OK;
    r.payload_address = 16'(b * GRANULE_BYTES + HDR_BYTES);
    live_blocks.push_back(b * GRANULE_BYTES + HDR_BYTES);
    return r;
  endfunction

  function automatic logic [1:0] heap_free(logic [15:0] addr);
    int unsigned g, p, n, off;
    bit          err;
    err = 1'b0;
    if (addr < HDR_BYTES) return ST_NONE;
    off = addr - HDR_BYTES;
    if (off % GRANULE_BYTES != 0 || off / GRANULE_BYTES >= N_GRAN) return ST_NONE;
    g = off / GRANULE_BYTES;
    if (!hp_used[g]) return ST_NONE;
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == addr) begin
        live_blocks.delete(i);
        break;
      end
    end
    hp_used[g] = 1'b0;
    // coalesce with free neighbors
    p = hp_prev[g];
    if (is_gran(p) && !hp_used[p]) begin
      heap_unlink(p);
      g = heap_join(p, g, err);
    end
    n = hp_next[g];
    if (is_gran(n) && !hp_used[n]) begin
      heap_unlink(n);
      g = heap_join(g, n, err);
    end
    heap_file(g);
    return err ? ST_MERGE : ST_OK;
  endfunction

  function automatic sfa_rsp_t heap_step(sfa_req_t q);
    sfa_rsp_t r;
    r = '{payload_address: '0, status: ST_NONE};
    case (q.operation)
      OP_ALLOC: r = heap_alloc(q.request_size);
      OP_FREE:  r.status = heap_free(q.block_address);
      OP_INIT: begin
        heap_init();
        r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [17:0] got, logic [17:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    sfa_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected item", {out_payload_address, out_status}, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (out_payload_address !== want.payload_address)
          report("payload_address", 18'(out_payload_address), 18'(want.payload_address));
        if (out_status !== want.status)
          report("status", 18'(out_status), 18'(want.status));
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(logic [1:0] op, logic [16:0] size, logic [15:0] addr);
    sfa_req_t q;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid         = 1'b1;
    in_operation     = op;
    in_request_size  = size;
    in_block_address = addr;
    do @(posedge clk); while (in_stall);
    q = '{operation: op, request_size: size, block_address: addr};
    expected_rsp.push_back(heap_step(q));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every outstanding result, then let the block settle
  task automatic drain();
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_heap_bytes(logic [16:0] value);
    drain();
    cfg_valid      = 1'b1;
    cfg_heap_bytes = value;
    do @(posedge clk); while (!cfg_ready);
    heap_size = 32'(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_before_init();
    send_item(OP_ALLOC, 17'd0, 16'd0);
    send_item(OP_ALLOC, 17'd1, 16'd0);
    send_item(OP_ALLOC, 17'h1FFFF, 16'hFFFF);
    send_item(OP_UNDEF, 17'd5, 16'd64);
  endtask

  task automatic test_directed();
    logic [15:0] a, b, c;
    write_heap_bytes(17'd64);
    send_item(OP_INIT, 17'd0, 16'd0);
    send_item(OP_ALLOC, 17'd8, 16'd0);
    write_heap_bytes(17'd65536);
    send_item(OP_INIT, 17'd0, 16'd0);
    send_item(OP_ALLOC, 17'd0, 16'd0);
    send_item(OP_ALLOC, 17'd65536, 16'd0);
    send_item(OP_ALLOC, 17'h1FFFF, 16'd0);
    send_item(OP_ALLOC, 17'd1, 16'd0);
    send_item(OP_ALLOC, 17'd100, 16'd0);
    send_item(OP_ALLOC, 17'd24, 16'd0);
    a = 16'(live_blocks[0]);
    b = 16'(live_blocks[1]);
    c = 16'(live_blocks[2]);
    // bad addresses: null, inside header, unaligned, top of range
    send_item(OP_FREE, 17'd0, 16'd0);
    send_item(OP_FREE, 17'd0, 16'd8);
    send_item(OP_FREE, 17'd0, 16'd69);
    send_item(OP_FREE, 17'd0, 16'hFFFF);
    // merge forward, a free with no merge, then both sides, then a double free
    send_item(OP_FREE, 17'd0, c);
    send_item(OP_FREE, 17'd0, a);
    send_item(OP_FREE, 17'd0, b);
    send_item(OP_FREE, 17'd0, b);
    send_item(OP_ALLOC, 17'd32768, 16'd0);
    send_item(OP_ALLOC, 17'd32768, 16'd0);
    send_item(OP_UNDEF, 17'h1FFFF, 16'hFFFF);
  endtask

  task automatic test_random(int n_items, logic [16:0] heap_val);
    int          pick;
    logic [15:0] addr;
    write_heap_bytes(heap_val);
    send_item(OP_INIT, 17'd0, 16'd0);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // mostly small requests, a few large
        if ($urandom_range(9) == 0) send_item(OP_ALLOC, 17'($urandom), 16'($urandom));
        else send_item(OP_ALLOC, 17'($urandom_range(1, 600)), 16'($urandom));
      end else if (pick < 88 && live_blocks.size() != 0) begin
        addr = 16'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
        send_item(OP_FREE, 17'($urandom), addr);
      end else if (pick < 93) begin
        send_item(OP_FREE, 17'($urandom), 16'($urandom));
      end else if (pick < 97) begin
        send_item(OP_FREE, 17'($urandom), 16'(HDR_BYTES + 8 * $urandom_range(8191)));
      end else if (pick < 99) begin
        send_item(OP_ALLOC, 17'd0, 16'($urandom));
      end else begin
        send_item(OP_UNDEF, 17'($urandom), 16'($urandom));
      end
      // one hold-off, halfway through, until the pipe is empty
      if (i == n_items / 2) drain();
    end
  endtask

  initial begin
    error_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_ALLOC;
    in_request_size  = '0;
    in_block_address = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_heap_bytes   = '0;
    heap_size        = 65536;
    for (int x = 0; x < N_CLASS; x++) hp_heads[x] = NONE;
    for (int g = 0; g < N_GRAN; g++) begin
      hp_next[g] = 0; hp_prev[g] = 0; hp_fnext[g] = 0; hp_fprev[g] = 0;
      hp_len[g] = 0; hp_used[g] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_before_init();
    test_directed();
    test_random(260, 17'd65536);
    send_idle_pct = 45;
    test_random(120, 17'd128);
    test_random(150, 17'h1FFFF);
    send_idle_pct = 0;  recv_stall_pct = 45;
    test_random(260, 17'($urandom_range(128, 65536)));
    send_idle_pct = 34; recv_stall_pct = 34;
    test_random(120, 17'd1003);
    test_random(160, 17'd4096);

    drain();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
